/* src/wrms_pkg.sv */
// Shared types, constants and state encodings for the windowed RMS onset detector.
`timescale 1ns / 1ps
package wrms_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 16;
  localparam int SUM_W    = 46;
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int MEAN_W   = 2 * SAMPLE_W - 1;
  localparam int RMS_W    = 16;
  localparam int ROOT_W   = 32;
  localparam int CFG_W    = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Register reset values.
  localparam logic [CFG_W-1:0] RESET_WINDOW_LENGTH   = 16'd32000;
  localparam logic [CFG_W-1:0] RESET_ONSET_THRESHOLD = 16'd500;

  // Default depth of the window queue between front and back.
  localparam int WRMS_QUEUE_DEPTH = 2;

  // Register index, decoded from address bit 2.
  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_ONSET_THRESHOLD = 1'b1;

  // One finished window handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } win_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } bk_state_t;

endpackage

/* src/windowed_rms_onset_detector.sv */
// Top level of the windowed RMS onset detector: register port, front, queue and back.
`timescale 1ns / 1ps
// Usage:
// Samples arrive on in_sample with an in_valid/in_ready transfer and are taken
// one per cycle. Each sample is squared and added to the running window sum.
// When the window reaches window_length samples (0 acts as 1), the sum and
// count move into a short queue and the window restarts at once.
// The back end divides the sum by the count one quotient bit a cycle and then
// takes the square root one root bit a cycle. The result appears on
// out_rms_level and out_onset_detected and stays until out_ready.
// Sample throughput is one per cycle; a window of fewer than about 64 samples
// is bounded by the divide/root sequencer, and once the queue is full in_ready
// drops until the receiver takes results.
// Registers: window_length at address 0, onset_threshold at address 4, both
// written over the APB-style port; pready is always high.
// Reset (rst_n low, synchronous) clears the sum, count and queue, idles the back end
// and sets window_length to 32000 and onset_threshold to 500.
module windowed_rms_onset_detector
  import wrms_pkg::*;
#(
  parameter int QUEUE_DEPTH = WRMS_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [RMS_W-1:0]           out_rms_level,
  output logic                       out_onset_detected,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  logic [CFG_W-1:0] window_length_r, window_length_nxt;
  logic [CFG_W-1:0] onset_threshold_r, onset_threshold_nxt;
  logic             cfg_wr;
  logic             push_valid, push_ready;
  win_t             push_data;
  logic             pop_valid, pop_ready;
  win_t             pop_data;

  // Register port: writes complete in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    window_length_nxt   = window_length_r;
    onset_threshold_nxt = onset_threshold_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH:   window_length_nxt   = pwdata[CFG_W-1:0];
        REG_ONSET_THRESHOLD: onset_threshold_nxt = pwdata[CFG_W-1:0];
        default:             window_length_nxt   = window_length_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_WINDOW_LENGTH:   prdata = APB_DW'(window_length_r);
      REG_ONSET_THRESHOLD: prdata = APB_DW'(onset_threshold_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r   <= RESET_WINDOW_LENGTH;
      onset_threshold_r <= RESET_ONSET_THRESHOLD;
    end else begin
      window_length_r   <= window_length_nxt;
      onset_threshold_r <= onset_threshold_nxt;
    end
  end

  wrms_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .window_length (window_length_r),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  wrms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wrms_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_data           (pop_data),
    .onset_threshold    (onset_threshold_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rms_level      (out_rms_level),
    .out_onset_detected (out_onset_detected)
  );

endmodule

/* src/wrms_front.sv */
// Front end: accepts samples, squares them and accumulates each window.
`timescale 1ns / 1ps
module wrms_front
  import wrms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [CFG_W-1:0]           window_length,
  output logic                       push_valid,
  input  logic                       push_ready,
  output win_t                       push_data
);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]     sq_r;
  logic [CNT_W-1:0]    sq_cnt_r;
  logic                sq_v_r, sq_v_nxt;
  logic                sq_last_r;
  logic [SAMPLE_W-1:0] mag;
  logic [2*SAMPLE_W-1:0] prod;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    limit;
  logic                last;
  logic                accept;
  logic                adv;
  logic [SUM_W-1:0]    sum_new;

  // Magnitude and square of the incoming sample; the most negative code maps to 32768.
  assign mag  = in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : SAMPLE_W'(in_sample);
  assign prod = mag * mag;

  // Window end decision is made when the sample is taken.
  assign cnt_inc = count_r + 1'b1;
  assign limit   = (window_length == '0) ? CNT_W'(1) : window_length;
  assign last    = (cnt_inc >= limit);

  // The accumulate stage stalls only when it closes a window and the queue is full.
  assign adv      = sq_v_r && (!sq_last_r || push_ready);
  assign in_ready = !sq_v_r || adv;
  assign accept   = in_valid && in_ready;

  assign sum_new    = sum_r + SUM_W'(sq_r);
  assign push_valid = sq_v_r && sq_last_r;
  assign push_data  = '{sum: sum_new, count: sq_cnt_r};

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = last ? '0 : cnt_inc;
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (adv) begin
      sum_nxt = sq_last_r ? '0 : sum_new;
    end
  end

  always_comb begin
    sq_v_nxt = sq_v_r;
    if (accept) begin
      sq_v_nxt = 1'b1;
    end else if (adv) begin
      sq_v_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_v_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_v_r  <= sq_v_nxt;
    end
  end

  // Squared sample waiting to be added.
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r      <= prod[SQ_W-1:0];
      sq_cnt_r  <= cnt_inc;
      sq_last_r <= last;
    end
  end

  // The count closes a window at the latest at 65535, so it never rests at all ones.
  assert property (@(posedge clk) disable iff (!rst_n) count_r != '1)
    else $error("front: sample count reached all ones");

  // A closing sample that the queue refuses stays in the accumulate stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> (sq_v_r && sq_last_r))
    else $error("front: refused window was dropped");

endmodule

/* src/wrms_fifo.sv */
// Short queue of finished windows between the front and back ends.
`timescale 1ns / 1ps
module wrms_fifo
  import wrms_pkg::*;
#(
  parameter int DEPTH = WRMS_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  win_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output win_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  win_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (occ_r != OCC_W'(DEPTH));
  assign pop_valid  = (occ_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_q[rd_ptr_r];

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (pop && !push) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_q[wr_ptr_r] <= push_data;
    end
  end

  // Occupancy stays within the queue depth.
  assert property (@(posedge clk) disable iff (!rst_n) occ_r <= OCC_W'(DEPTH))
    else $error("fifo: occupancy above depth");

endmodule

/* src/wrms_back.sv */
// Back end: divides each window sum by its count, takes the square root and holds the result.
`timescale 1ns / 1ps
module wrms_back
  import wrms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  win_t              pop_data,
  input  logic [CFG_W-1:0]  onset_threshold,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RMS_W-1:0]  out_rms_level,
  output logic              out_onset_detected
);

  localparam int STEP_W = $clog2(SUM_W);

  bk_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]  dq_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic [ROOT_W-1:0] v_r, root_r, bit_r;
  logic              load;
  logic              div_en;
  logic              sqrt_en;
  logic              div_done;
  logic              sqrt_done;
  logic [CNT_W:0]    rem_sh;
  logic              q_bit;
  logic [SUM_W-1:0]  dq_nxt;
  logic [ROOT_W-1:0] trial;
  logic              take;

  // One restoring-division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_r, dq_r[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});
  assign dq_nxt = {dq_r[SUM_W-2:0], q_bit};

  // One square-root step: try the next root bit against the remaining value.
  assign trial = root_r + bit_r;
  assign take  = (v_r >= trial);

  assign div_done  = (step_r == STEP_W'(SUM_W - 1));
  assign sqrt_done = (step_r == STEP_W'(RMS_W - 1));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = BK_DIV;
      BK_DIV:  if (div_done) state_nxt = BK_SQRT;
      BK_SQRT: if (sqrt_done) state_nxt = BK_OUT;
      BK_OUT:  if (out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    pop_ready = 1'b0;
    load      = 1'b0;
    div_en    = 1'b0;
    sqrt_en   = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        load      = pop_valid;
      end
      BK_DIV:  div_en    = 1'b1;
      BK_SQRT: sqrt_en   = 1'b1;
      BK_OUT:  out_valid = 1'b1;
      default: pop_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Division and square-root datapath.
  always_ff @(posedge clk) begin
    if (load) begin
      dq_r   <= pop_data.sum;
      den_r  <= pop_data.count;
      rem_r  <= '0;
      step_r <= '0;
    end else if (div_en) begin
      dq_r   <= dq_nxt;
      rem_r  <= q_bit ? CNT_W'(rem_sh - {1'b0, den_r}) : rem_sh[CNT_W-1:0];
      step_r <= div_done ? '0 : step_r + 1'b1;
      if (div_done) begin
        // An empty window never reaches here, but a zero count gives a zero mean.
        v_r    <= (den_r == '0) ? '0 : ROOT_W'(dq_nxt[MEAN_W-1:0]);
        root_r <= '0;
        bit_r  <= ROOT_W'(1) << (2 * (RMS_W - 1));
      end
    end else if (sqrt_en) begin
      v_r    <= take ? v_r - trial : v_r;
      root_r <= take ? (root_r >> 1) + bit_r : root_r >> 1;
      bit_r  <= bit_r >> 2;
      step_r <= step_r + 1'b1;
    end
  end

  assign out_rms_level      = root_r[RMS_W-1:0];
  assign out_onset_detected = (root_r[RMS_W-1:0] >= onset_threshold);

  // The root of a mean of at most 2^30 never exceeds 32768.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (root_r <= ROOT_W'(32768)))
    else $error("back: root out of range");

  // A window is taken only when the sequencer is idle and then division starts.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (state_r == BK_DIV && step_r == '0))
    else $error("back: window taken without starting division");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the windowed RMS onset detector: directed table, random phases.
`timescale 1ns / 1ps
module testbench
  import wrms_pkg::*;
();

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 1230;
  localparam int SETTLE_CYCLES = 100;
  // The limit covers the slowest run: every sample closing a window at the
  // divide/root rate with the longest receiver stalls.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_WINDOW   = 100;
  localparam int PEAK_LEVEL    = 32768;

  typedef struct {
    logic [RMS_W-1:0] rms;
    logic             onset;
  } level_t;

  typedef enum { ROW_SAMPLE, ROW_SET_LENGTH, ROW_SET_THRESHOLD } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    int               value;
    bit               typed;
    logic [RMS_W-1:0] rms;
    logic             onset;
  } row_t;

  typedef enum { MIX_FULL, MIX_QUIET, MIX_MODERATE, MIX_EXTREME } sample_mix_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [RMS_W-1:0]           out_rms_level;
  logic                       out_onset_detected;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  // Predictor copy of the registers and the open window.
  logic [CFG_W-1:0] length_reg;
  logic [CFG_W-1:0] threshold_reg;
  logic [SUM_W-1:0] energy_sum;
  logic [CNT_W-1:0] window_fill;

  level_t expected_levels[$];
  row_t   directed_rows[$];

  int mismatches      = 0;
  int samples_sent    = 0;
  int windows_checked = 0;
  int register_writes = 0;
  int phases_run      = 0;
  int hold_off_cycles = 0;
  int cycle_count     = 0;
  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;

  windowed_rms_onset_detector u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rms_level      (out_rms_level),
    .out_onset_detected (out_onset_detected),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Floor of the square root, one root bit at a time from the top.
  function automatic logic [RMS_W:0] floor_root(input logic [MEAN_W-1:0] v);
    logic [RMS_W:0]     root;
    logic [2*RMS_W+1:0] trial;
    int                 b;
    root = '0;
    for (b = RMS_W; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial[RMS_W:0];
    end
    return root;
  endfunction

  // Adds one sample to the open window; returns 1 and the level when it closes.
  function automatic bit accumulate_sample(input logic signed [SAMPLE_W-1:0] s,
                                           output level_t lvl);
    logic [SAMPLE_W:0] mag;
    logic [CNT_W-1:0]  limit;
    logic [SUM_W-1:0]  mean;
    logic [RMS_W:0]    root;
    mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    energy_sum = energy_sum + mag * mag;
    window_fill = window_fill + 1'b1;
    limit = (length_reg == '0) ? 16'd1 : length_reg;
    lvl.rms = '0;
    lvl.onset = 1'b0;
    if (window_fill < limit && window_fill != '0) return 1'b0;
    // The mean uses the samples actually summed, not the register.
    mean = (window_fill != '0) ? energy_sum / window_fill : '0;
    root = floor_root(mean[MEAN_W-1:0]);
    lvl.rms = root[RMS_W-1:0];
    lvl.onset = (root >= threshold_reg);
    energy_sum = '0;
    window_fill = '0;
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix);
    logic [31:0] raw;
    raw = $urandom;
    case (mix)
      MIX_QUIET:    return SAMPLE_W'($urandom_range(0, 2000) - 1000);
      MIX_MODERATE: return SAMPLE_W'($urandom_range(0, 16000) - 8000);
      MIX_EXTREME: begin
        case (raw[18:16])
          3'd0:    return 16'sh8000;
          3'd1:    return 16'sh7FFF;
          3'd2:    return 16'sh0000;
          3'd3:    return 16'shFFFF;
          3'd4:    return 16'sh0001;
          default: return raw[15:0];
        endcase
      end
      default: return raw[15:0];
    endcase
  endfunction

  function automatic void add_row(input row_kind_t kind, input int value, input bit typed,
                                  input int rms, input bit onset);
    row_t r;
    r.kind = kind;
    r.value = value;
    r.typed = typed;
    r.rms = RMS_W'(rms);
    r.onset = onset;
    directed_rows.push_back(r);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Offers one sample and records its expected level once the transfer happens.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                             input level_t typed_level);
    int     gap;
    level_t lvl;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (accumulate_sample(s, lvl)) begin
      if (typed) expected_levels.push_back(typed_level);
      else expected_levels.push_back(lvl);
    end
  endtask

  // Stops offering, waits for every expected level, then lets the back end settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup phase, access phase, then idle; upper data bits carry noise
  // the block must drop.
  task automatic write_register(input logic index, input logic [CFG_W-1:0] value);
    logic [31:0] noise;
    noise = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= {noise[APB_DW-1:CFG_W], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (index == REG_WINDOW_LENGTH) length_reg = value;
    else threshold_reg = value;
    register_writes++;
  endtask

  // Cycle limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d levels still expected.",
               cycle_count, expected_levels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random or long hold-offs, then compare each transfer in order.
  initial begin : level_checker
    level_t want;
    int     pause;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        pause = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        pause = rx_steady ? 0 : $urandom_range(0, 11);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_levels.size() == 0) begin
        note_mismatch($sformatf("unexpected result: rms %0d onset %0b",
                                out_rms_level, out_onset_detected));
      end else begin
        want = expected_levels.pop_front();
        windows_checked++;
        if (out_rms_level !== want.rms)
          note_mismatch($sformatf("window %0d rms_level: expected %0d, got %0d",
                                  windows_checked, want.rms, out_rms_level));
        if (out_onset_detected !== want.onset)
          note_mismatch($sformatf("window %0d onset_detected: expected %0b, got %0b",
                                  windows_checked, want.onset, out_onset_detected));
      end
    end
  end

  initial begin : sample_source
    level_t           lvl;
    row_t             row;
    sample_mix_t      mix;
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] thr;
    int               n;
    int               r;
    int               phase_items;
    int               random_sent;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    length_reg = RESET_WINDOW_LENGTH;
    threshold_reg = RESET_ONSET_THRESHOLD;
    energy_sum = '0;
    window_fill = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Reset values first: three samples open a long window,
    // then the window is cut to one sample so the next sample closes it.
    add_row(ROW_SAMPLE, -32768, 0, 0, 0);
    add_row(ROW_SAMPLE, 32767, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 0, 0, 0);
    add_row(ROW_SET_LENGTH, 1, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 0, 0, 0);
    // Single-sample windows against the reset threshold of 500.
    add_row(ROW_SAMPLE, -32768, 1, 32768, 1);
    add_row(ROW_SAMPLE, 32767, 1, 32767, 1);
    add_row(ROW_SAMPLE, 0, 1, 0, 0);
    add_row(ROW_SAMPLE, 499, 1, 499, 0);
    add_row(ROW_SAMPLE, 500, 1, 500, 1);
    add_row(ROW_SAMPLE, -1, 1, 1, 0);
    // Threshold extremes.
    add_row(ROW_SET_THRESHOLD, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 0, 1, 0, 1);
    add_row(ROW_SET_THRESHOLD, 32768, 0, 0, 0);
    add_row(ROW_SAMPLE, 32767, 1, 32767, 0);
    add_row(ROW_SAMPLE, -32768, 1, 32768, 1);
    // A zero window length behaves as one.
    add_row(ROW_SET_LENGTH, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, 1, 1, 1, 0);
    add_row(ROW_SAMPLE, -181, 1, 181, 0);
    add_row(ROW_SET_THRESHOLD, 181, 0, 0, 0);
    add_row(ROW_SAMPLE, 181, 1, 181, 1);
    // Two-sample windows: a mean of 12.5 floors to 12 before the root.
    add_row(ROW_SET_LENGTH, 2, 0, 0, 0);
    add_row(ROW_SAMPLE, 3, 0, 0, 0);
    add_row(ROW_SAMPLE, 4, 1, 3, 0);
    add_row(ROW_SAMPLE, 21845, 0, 0, 0);
    add_row(ROW_SAMPLE, -21846, 0, 0, 0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_SAMPLE: begin
          lvl.rms = row.rms;
          lvl.onset = row.onset;
          send_sample(SAMPLE_W'(row.value), row.typed, lvl);
        end
        ROW_SET_LENGTH: begin
          wait_for_results();
          write_register(REG_WINDOW_LENGTH, CFG_W'(row.value));
        end
        default: begin
          wait_for_results();
          write_register(REG_ONSET_THRESHOLD, CFG_W'(row.value));
        end
      endcase
    end

    // A long window of the loudest samples, back to back, at the peak threshold.
    wait_for_results();
    write_register(REG_WINDOW_LENGTH, CFG_W'(LONG_WINDOW));
    write_register(REG_ONSET_THRESHOLD, CFG_W'(PEAK_LEVEL));
    tx_steady = 1'b1;
    lvl.rms = RMS_W'(PEAK_LEVEL);
    lvl.onset = 1'b1;
    for (n = 1; n <= LONG_WINDOW; n++) send_sample(16'sh8000, n == LONG_WINDOW, lvl);

    // Random phases. The first two hold the receiver off so the queue fills.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_for_results();
      r = $urandom_range(0, 3);
      mix = sample_mix_t'(r);
      r = $urandom_range(0, 99);
      if (r < 8) len = 0;
      else if (r < 25) len = 1;
      else if (r < 65) len = CFG_W'($urandom_range(2, 16));
      else if (r < 85) len = CFG_W'($urandom_range(17, 80));
      else if (r < 95) len = CFG_W'($urandom_range(81, 400));
      else len = CFG_W'($urandom_range(1000, 65535));
      r = $urandom_range(0, 99);
      if (r < 12) thr = 0;
      else if (r < 22) thr = CFG_W'(PEAK_LEVEL);
      else if (r < 27) thr = 16'hFFFF;
      else if (mix == MIX_QUIET) thr = CFG_W'($urandom_range(0, 800));
      else if (mix == MIX_MODERATE) thr = CFG_W'($urandom_range(0, 6000));
      else thr = CFG_W'($urandom_range(0, 30000));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(20, 120);
      if (phases_run < 2) begin
        mix = MIX_FULL;
        len = (phases_run == 0) ? 16'd1 : 16'd3;
        tx_steady = 1'b1;
        phase_items = 80;
      end
      write_register(REG_WINDOW_LENGTH, len);
      write_register(REG_ONSET_THRESHOLD, thr);
      if (phases_run < 2) hold_off_cycles = (phases_run == 0) ? 600 : 300;
      for (n = 0; n < phase_items && random_sent < RANDOM_ITEMS; n++) begin
        send_sample(draw_sample(mix), 1'b0, lvl);
        random_sent++;
      end
      phases_run++;
    end
    wait_for_results();

    $display("Covered %0d samples: directed table, one long loud window, %0d random phases.",
             samples_sent, phases_run);
    $display("Checked %0d windows over %0d register writes; %0d field mismatches.",
             windows_checked, register_writes, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
